// File: hdl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ISOTP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ISOTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/isotp_pkg.sv
package isotp_pkg;

    localparam int MAX_REQUEST_DEF = 256;
    localparam int MAX_BURST       = 36;
    localparam int BURST_W         = 6;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_W           = 32;
    localparam int LEN_W           = 12;

    localparam logic [3:0] PCI_FF      = 4'h1;
    localparam logic [3:0] PCI_CF      = 4'h2;
    localparam logic [3:0] PCI_FC      = 4'h3;
    localparam logic [7:0] FC_CTS_BYTE = 8'h30;

    localparam logic ACTION_REQ   = 1'b0;
    localparam logic ACTION_FRAME = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REQUEST_ID  = 1'b0,
        REG_RESPONSE_ID = 1'b1
    } isotp_reg_t;

    typedef enum logic [1:0] {
        KIND_TX    = 2'd0,
        KIND_RESP  = 2'd1,
        KIND_EMPTY = 2'd2
    } isotp_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_SEND,
        ST_BURST,
        ST_STREAM,
        ST_FINISH
    } isotp_state_t;

    typedef enum logic [1:0] {
        THEN_IDLE,
        THEN_BURST,
        THEN_STREAM
    } isotp_then_t;

    typedef struct packed {
        logic        action;
        logic [7:0]  req_byte;
        logic        req_last;
        logic [31:0] rx_id;
        logic [3:0]  rx_len;
        logic [63:0] rx_data;
    } isotp_in_t;

    typedef struct packed {
        isotp_kind_t kind;
        logic [63:0] tx_data;
        logic [7:0]  tx_delay;
        logic [7:0]  resp_byte;
        logic        resp_last;
    } isotp_out_t;

endpackage

// File: hdl/isotp_req_mem.sv
module isotp_req_mem #(
    parameter int DEPTH = isotp_pkg::MAX_REQUEST_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: hdl/isotp_engine.sv
`include "assert_macros.svh"

module isotp_engine #(
    parameter int MAX_REQUEST = isotp_pkg::MAX_REQUEST_DEF,
    parameter int AW          = $clog2(MAX_REQUEST)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  isotp_pkg::isotp_in_t  in_data,
    input  logic                  out_free,
    output logic                  emit,
    output isotp_pkg::isotp_out_t emit_data,
    input  logic [31:0]           response_id,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [7:0]            mem_wdata,
    output logic                  mem_re,
    output logic [AW-1:0]         mem_raddr,
    input  logic [7:0]            mem_rdata
);
    import isotp_pkg::*;

    localparam int CW = $clog2(MAX_REQUEST + 1);
    localparam int GW = $clog2(MAX_REQUEST + 16);

    isotp_state_t         state_reg, state_next;
    isotp_then_t          then_reg, then_next;
    logic [CW-1:0]        rc_reg, rc_next;
    logic [GW-1:0]        base_reg, base_next;
    logic [3:0]           seq_reg, seq_next;
    logic                 busy_reg, busy_next;
    logic                 drop_reg, drop_next;
    logic [LEN_W-1:0]     expect_reg, expect_next;
    logic [LEN_W-1:0]     got_reg, got_next;
    logic [63:0]          tx_reg, tx_next;
    logic [7:0]           delay_reg, delay_next;
    logic [3:0]           slot_reg, slot_next;
    logic [GW-1:0]        gaddr_reg, gaddr_next;
    logic                 pend_reg, pend_next;
    logic [2:0]           pend_slot_reg, pend_slot_next;
    logic                 pend_keep_reg, pend_keep_next;
    logic [63:0]          rx_reg, rx_next;
    logic [3:0]           bi_reg, bi_next;
    logic                 fin_all_reg, fin_all_next;
    logic [BURST_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]           fc_count_reg, fc_count_next;

    logic                 accept;
    logic                 frame_ok;
    logic [3:0]           hi;
    logic [7:0]           b0, b1, b2;
    logic                 gather_done;
    logic                 burst_go;
    logic                 stream_want;
    logic                 stream_end;
    logic                 fin_now;
    logic [CW-1:0]        rc_new;
    logic [LEN_W-1:0]     len12;
    logic [3:0]           dlc;
    logic [7:0]           sf_len;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && (state_reg == ST_IDLE);
    assign b0          = in_data.rx_data[7:0];
    assign b1          = in_data.rx_data[15:8];
    assign b2          = in_data.rx_data[23:16];
    assign hi          = b0[7:4];
    assign frame_ok    = accept && (in_data.action == ACTION_FRAME) && busy_reg
                         && (in_data.rx_id == response_id);
    assign gather_done = slot_reg[3] && !pend_reg;
    assign burst_go    = (rc_reg >= CW'(8)) && (base_reg < GW'(rc_reg))
                         && ((fc_count_reg == 8'd0) || ({2'b00, cnt_reg} < fc_count_reg))
                         && (cnt_reg < BURST_W'(MAX_BURST));
    assign stream_want = got_reg < expect_reg;
    assign stream_end  = bi_reg[3];
    assign fin_now     = fin_all_reg || (got_reg == expect_reg);
    assign rc_new      = rc_reg + CW'(rc_reg < CW'(MAX_REQUEST));
    assign len12       = LEN_W'(rc_new);
    assign dlc         = (in_data.rx_len > 4'd8) ? 4'd8 : in_data.rx_len;
    assign sf_len      = (b0 < {4'd0, dlc}) ? b0
                         : ((dlc != 4'd0) ? {4'd0, dlc - 4'd1} : 8'd0);
    assign mem_waddr   = rc_reg[AW-1:0];
    assign mem_wdata   = in_data.req_byte;
    assign mem_raddr   = gaddr_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.action == ACTION_REQ)
                    begin
                        if (!drop_reg && !busy_reg && in_data.req_last)
                        begin
                            state_next = ST_GATHER;
                        end
                    end
                    else if (frame_ok)
                    begin
                        case (hi)
                            PCI_FC:  state_next = ST_BURST;
                            PCI_FF:  state_next = ST_SEND;
                            default: state_next = ST_STREAM;
                        endcase
                    end
                end
            end
            ST_GATHER:
            begin
                if (gather_done)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    case (then_reg)
                        THEN_BURST:  state_next = ST_BURST;
                        THEN_STREAM: state_next = ST_STREAM;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BURST:
            begin
                state_next = burst_go ? ST_GATHER : ST_IDLE;
            end
            ST_STREAM:
            begin
                if (stream_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!fin_now || (expect_reg != '0) || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        then_next      = then_reg;
        rc_next        = rc_reg;
        base_next      = base_reg;
        seq_next       = seq_reg;
        busy_next      = busy_reg;
        drop_next      = drop_reg;
        expect_next    = expect_reg;
        got_next       = got_reg;
        tx_next        = tx_reg;
        delay_next     = delay_reg;
        slot_next      = slot_reg;
        gaddr_next     = gaddr_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        pend_keep_next = pend_keep_reg;
        rx_next        = rx_reg;
        bi_next        = bi_reg;
        fin_all_next   = fin_all_reg;
        cnt_next       = cnt_reg;
        fc_count_next  = fc_count_reg;
        emit           = 1'b0;
        emit_data      = '0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_data.action == ACTION_REQ))
                begin
                    if (drop_reg)
                    begin
                        if (in_data.req_last)
                        begin
                            drop_next = 1'b0;
                        end
                    end
                    else if (busy_reg)
                    begin
                        if (!in_data.req_last)
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        mem_we  = rc_reg < CW'(MAX_REQUEST);
                        rc_next = rc_new;
                        if (in_data.req_last)
                        begin
                            busy_next   = 1'b1;
                            expect_next = '0;
                            got_next    = '0;
                            seq_next    = 4'd1;
                            base_next   = GW'(6);
                            gaddr_next  = '0;
                            pend_next   = 1'b0;
                            delay_next  = 8'd0;
                            then_next   = THEN_IDLE;
                            if (rc_new < CW'(8))
                            begin
                                tx_next   = {56'd0, len12[7:0]};
                                slot_next = 4'd1;
                            end
                            else
                            begin
                                tx_next   = {48'd0, len12[7:0], PCI_FF, len12[11:8]};
                                slot_next = 4'd2;
                            end
                        end
                    end
                end
                else if (frame_ok)
                begin
                    case (hi)
                        PCI_FC:
                        begin
                            fc_count_next = b1;
                            delay_next    = b2;
                            cnt_next      = '0;
                        end
                        PCI_FF:
                        begin
                            tx_next      = {56'd0, FC_CTS_BYTE};
                            delay_next   = 8'd0;
                            then_next    = THEN_STREAM;
                            expect_next  = {b0[3:0], b1};
                            got_next     = '0;
                            rx_next      = in_data.rx_data;
                            bi_next      = 4'd2;
                            fin_all_next = 1'b0;
                        end
                        PCI_CF:
                        begin
                            rx_next      = in_data.rx_data;
                            bi_next      = 4'd1;
                            fin_all_next = 1'b0;
                        end
                        default:
                        begin
                            expect_next  = LEN_W'(sf_len);
                            got_next     = '0;
                            rx_next      = in_data.rx_data;
                            bi_next      = 4'd1;
                            fin_all_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_GATHER:
            begin
                if (pend_reg)
                begin
                    tx_next[8*pend_slot_reg +: 8] = pend_keep_reg ? mem_rdata : 8'd0;
                end
                if (!slot_reg[3])
                begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_slot_next = slot_reg[2:0];
                    pend_keep_next = gaddr_reg < GW'(rc_reg);
                    slot_next      = slot_reg + 4'd1;
                    gaddr_next     = gaddr_reg + GW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    emit_data.kind    = KIND_TX;
                    emit_data.tx_data = tx_reg;
                    emit_data.tx_delay = delay_reg;
                    if (then_reg == THEN_BURST)
                    begin
                        seq_next  = seq_reg + 4'd1;
                        base_next = base_reg + GW'(7);
                        cnt_next  = cnt_reg + BURST_W'(1);
                    end
                end
            end
            ST_BURST:
            begin
                if (burst_go)
                begin
                    tx_next    = {56'd0, PCI_CF, seq_reg};
                    slot_next  = 4'd1;
                    gaddr_next = base_reg;
                    pend_next  = 1'b0;
                    then_next  = THEN_BURST;
                end
            end
            ST_STREAM:
            begin
                if (!stream_end)
                begin
                    if (stream_want)
                    begin
                        if (out_free)
                        begin
                            emit                = 1'b1;
                            emit_data.kind      = KIND_RESP;
                            emit_data.resp_byte = rx_reg[8*bi_reg[2:0] +: 8];
                            emit_data.resp_last = (got_reg + LEN_W'(1)) == expect_reg;
                            got_next            = got_reg + LEN_W'(1);
                            bi_next             = bi_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        bi_next = bi_reg + 4'd1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (fin_now && ((expect_reg != '0) || out_free))
                begin
                    if (expect_reg == '0)
                    begin
                        emit                = 1'b1;
                        emit_data.kind      = KIND_EMPTY;
                        emit_data.resp_last = 1'b1;
                    end
                    busy_next   = 1'b0;
                    rc_next     = '0;
                    base_next   = GW'(6);
                    expect_next = '0;
                    got_next    = '0;
                end
            end
            default:
            begin
                then_next = THEN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            then_reg     <= THEN_IDLE;
            rc_reg       <= '0;
            base_reg     <= GW'(6);
            seq_reg      <= 4'd1;
            busy_reg     <= 1'b0;
            drop_reg     <= 1'b0;
            expect_reg   <= '0;
            got_reg      <= '0;
            slot_reg     <= '0;
            gaddr_reg    <= '0;
            pend_reg     <= 1'b0;
            bi_reg       <= '0;
            fin_all_reg  <= 1'b0;
            cnt_reg      <= '0;
            fc_count_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            then_reg     <= then_next;
            rc_reg       <= rc_next;
            base_reg     <= base_next;
            seq_reg      <= seq_next;
            busy_reg     <= busy_next;
            drop_reg     <= drop_next;
            expect_reg   <= expect_next;
            got_reg      <= got_next;
            slot_reg     <= slot_next;
            gaddr_reg    <= gaddr_next;
            pend_reg     <= pend_next;
            bi_reg       <= bi_next;
            fin_all_reg  <= fin_all_next;
            cnt_reg      <= cnt_next;
            fc_count_reg <= fc_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg        <= tx_next;
        delay_reg     <= delay_next;
        pend_slot_reg <= pend_slot_next;
        pend_keep_reg <= pend_keep_next;
        rx_reg        <= rx_next;
    end

    `ISOTP_ASSERT_IMP(a_emit_free, emit, out_free, "result emitted into a full output stage")
    `ISOTP_ASSERT_IMP(a_got_le_expect, 1'b1, got_reg <= expect_reg, "received count overran")
    `ISOTP_ASSERT_IMP(a_pend_gather, pend_reg, state_reg == ST_GATHER, "read outstanding off gather")
    `ISOTP_ASSERT_NEXT(a_seq_step, emit && (state_reg == ST_SEND) && (then_reg == THEN_BURST),
        seq_reg == $past(seq_reg) + 4'd1, "sequence number did not advance")
endmodule

// File: hdl/isotp_segment_reassemble_top.sv
// Request byte: one transaction per cycle while idle; the last byte stalls the input while its frame is built.
// Flow control: each released consecutive frame is built from 7 pipelined store reads, then sent.
// Received frame: walked one data byte position at a time, holding while the output stage is full.
// One input transaction at a time; output stage register decouples the result side.
// Reset: asynchronous, active low; control clears, request store is not cleared.
module isotp_segment_reassemble_top #(
    parameter int MAX_REQUEST = isotp_pkg::MAX_REQUEST_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  isotp_pkg::isotp_in_t                 in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output isotp_pkg::isotp_out_t                out_data,
    input  logic                                 cfg_we,
    input  logic [isotp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [isotp_pkg::CFG_W-1:0]          cfg_wdata
);
    import isotp_pkg::*;

    localparam int AW = $clog2(MAX_REQUEST);

    logic [31:0]   resp_id_reg;
    logic          out_valid_reg;
    isotp_out_t    out_data_reg;
    logic          out_free;
    logic          emit;
    isotp_out_t    emit_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_RESPONSE_ID))
            begin
                resp_id_reg <= cfg_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= emit_data;
        end
    end

    isotp_engine #(
        .MAX_REQUEST(MAX_REQUEST),
        .AW(AW)
    ) u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_free(out_free),
        .emit(emit),
        .emit_data(emit_data),
        .response_id(resp_id_reg),
        .mem_we(mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re(mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    isotp_req_mem #(
        .DEPTH(MAX_REQUEST),
        .AW(AW)
    ) u_req_mem (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re(mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );
endmodule
